@@ rtl/arinc429_bipolar_rz_transmitter_defines.svh @@
// assertion macros for the bipolar return-to-zero transmitter
// expects clk_i and rst_ni in the scope of each use
`ifndef ARINC429_BIPOLAR_RZ_TRANSMITTER_DEFINES_SVH
`define ARINC429_BIPOLAR_RZ_TRANSMITTER_DEFINES_SVH

// check a property on every clock edge out of reset
`define A429_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define A429_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/a429_tx_pkg.sv @@
// shared types and constants for the bipolar return-to-zero transmitter
// no dependencies
package a429_tx_pkg;

  // word geometry
  localparam int WORD_BITS = 32;
  localparam int IN_BITS   = 32;
  localparam int POS_W     = $clog2(WORD_BITS);

  // configuration register map
  localparam int GAP_W = 8;
  localparam logic [GAP_W-1:0] GAP_RESET = 8'd8;
  localparam logic REG_GAP = 1'b0;

  // input transfer payload
  typedef struct packed {
    logic              post_word;
    logic [IN_BITS-1:0] word_in;
  } a429_in_t;

  // output transfer payload
  typedef struct packed {
    logic line_a;
    logic line_b;
    logic busy_res;
    logic word_loaded;
  } a429_out_t;

  // per-tick control to the shift cells
  typedef struct packed {
    logic load;
    logic shift;
  } a429_cell_ctl_t;

endpackage

@@ rtl/arinc429_bipolar_rz_transmitter.sv @@
// top level of the bipolar return-to-zero word transmitter
// depends on a429_tx_pkg, a429_tx_cell and the assertion macro header
//
// channel  | direction | payload     | meaning
// in       | input     | a429_in_t   | one half-bit tick, optional word post
// out      | output    | a429_out_t  | line levels and status for that tick
// apb      | input     | gap (8 bit) | null half-bits after each word
//
// one tick is taken every clock cycle while the output is not stalled; its result appears
// in the output register in the next cycle, set by the single state update per tick
// the word shifts one cell per bit through a chain of WORD_BITS cells
// a stalled output holds the result and stops intake until it is taken
// reset leaves the block idle with no output valid and a gap of 8
`include "arinc429_bipolar_rz_transmitter_defines.svh"
module arinc429_bipolar_rz_transmitter
  import a429_tx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  a429_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output a429_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GAP_W-1:0]   gap_cfg_q;
  logic               pend_q, pend_d;
  logic [IN_BITS-1:0] pend_word_q, pend_word_d;
  logic               active_q, active_d;
  logic               half_q, half_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [GAP_W-1:0]   gap_q, gap_d;
  logic               out_valid_q;
  a429_out_t          out_q, out_d;

  logic               tick;
  logic               pend_any;
  logic               load;
  logic               act;
  logic               half_eff;
  logic [POS_W-1:0]   pos_eff;
  logic [IN_BITS-1:0] load_word;
  logic               tx_bit;
  a429_cell_ctl_t     cell_ctl;
  logic [WORD_BITS-1:0] chain;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAP) ? {{(32-GAP_W){1'b0}}, gap_cfg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_cfg_q <= GAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAP)) begin
      gap_cfg_q <= pwdata[GAP_W-1:0];
    end
  end

  // handshake: take a tick whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  // pending word and load decision
  assign pend_any  = in_data_i.post_word || pend_q;
  assign load_word = in_data_i.post_word ? in_data_i.word_in : pend_word_q;
  assign load      = pend_any && !active_q;
  assign act       = active_q || load;
  assign half_eff  = load ? 1'b0 : half_q;
  assign pos_eff   = load ? '0 : pos_q;
  assign tx_bit    = load ? load_word[0] : chain[0];

  // tick sequencer
  always_comb begin
    pend_d      = pend_q;
    pend_word_d = pend_word_q;
    active_d    = active_q;
    half_d      = half_q;
    pos_d       = pos_q;
    gap_d       = gap_q;
    cell_ctl    = '0;
    out_d       = '0;
    if (tick) begin
      if (in_data_i.post_word) begin
        pend_d      = 1'b1;
        pend_word_d = in_data_i.word_in;
      end
      if (load) begin
        pend_d        = 1'b0;
        cell_ctl.load = 1'b1;
        out_d.word_loaded = 1'b1;
      end
      active_d = act;
      half_d   = half_eff;
      pos_d    = pos_eff;
      if (act) begin
        out_d.busy_res = 1'b1;
        if (gap_q != '0) begin
          // trailing null gap
          gap_d = gap_q - 1'b1;
          if (gap_q == GAP_W'(1)) begin
            active_d = 1'b0;
            pos_d    = '0;
          end
        end else if (!half_eff) begin
          // first half carries the bit
          out_d.line_a = tx_bit;
          out_d.line_b = !tx_bit;
          half_d       = 1'b1;
        end else begin
          // second half is null, move to the next bit
          half_d         = 1'b0;
          cell_ctl.shift = 1'b1;
          if (pos_eff == POS_W'(WORD_BITS - 1)) begin
            pos_d = '0;
            gap_d = gap_cfg_q;
            if (gap_cfg_q == '0) begin
              active_d = 1'b0;
            end
          end else begin
            pos_d = pos_eff + 1'b1;
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      active_q    <= 1'b0;
      half_q      <= 1'b0;
      pos_q       <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      active_q <= active_d;
      half_q   <= half_d;
      pos_q    <= pos_d;
      gap_q    <= gap_d;
      if (tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_word_q <= pend_word_d;
    if (tick) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shift chain, bit 0 is the one on the line
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    logic load_bit;
    logic next_bit;
    if (i < IN_BITS) begin : g_in
      assign load_bit = load_word[i];
    end else begin : g_pad
      assign load_bit = 1'b0;
    end
    if (i == WORD_BITS - 1) begin : g_end
      assign next_bit = 1'b0;
    end else begin : g_mid
      assign next_bit = chain[i+1];
    end
    a429_tx_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .load_bit_i (load_bit),
      .next_bit_i (next_bit),
      .bit_o      (chain[i])
    );
  end

  // checks
  `A429_ASSERT(a_lines_exclusive, out_valid_q |-> !(out_q.line_a && out_q.line_b), "both lines high")
  `A429_ASSERT(a_load_drives_bit, out_valid_q && out_q.word_loaded |-> out_q.busy_res && (out_q.line_a ^ out_q.line_b), "load tick without a first half bit")
  `A429_ASSERT(a_gap_when_active, (gap_q != '0) || half_q |-> active_q, "gap or half set while idle")
  `A429_ASSERT(a_tick_gives_result, tick |=> out_valid_q, "accepted tick without result")
  `A429_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !active_q || !$past(rst_ni), "not idle after reset")

endmodule

@@ rtl/a429_tx_cell.sv @@
// one bit cell of the transmit shift chain
// depends on a429_tx_pkg
module a429_tx_cell
  import a429_tx_pkg::*;
(
  input  logic           clk_i,
  input  a429_cell_ctl_t ctl_i,
  input  logic           load_bit_i,
  input  logic           next_bit_i,
  output logic           bit_o
);

  logic bit_q;
  logic bit_d;

  // load a new word bit or take the neighbor's bit
  always_comb begin
    bit_d = bit_q;
    if (ctl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctl_i.shift) begin
      bit_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule
